// ===== src/adler32_pkg.sv =====
// Shared types, constants and the modular reduction for the Adler-32 unit.
`default_nettype none
package adler32_pkg;

  localparam logic [16:0] ADLER_MOD   = 17'd65521;
  localparam int          HALF_BITS   = 16;
  localparam int          QUEUE_DEPTH = 4;

  // One classified byte on its way from the front stage to the sum engine.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] seed_a;
    logic [15:0] seed_b;
  } item_t;

  typedef struct packed {
    logic [15:0] sum_a;
    logic [15:0] sum_b;
  } sum_stat_t;

  // One conditional subtract; valid for any input below twice the modulus.
  function automatic logic [15:0] reduce_once(input logic [16:0] v);
    logic [16:0] d;
    d = v - ADLER_MOD;
    reduce_once = (v >= ADLER_MOD) ? d[15:0] : v[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/adler32_front.sv =====
// Input stage: registers an item and brings both seed halves below the modulus.
`default_nettype none
module adler32_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [39:0]         in_tdata,
  input  wire                 in_tuser,
  input  wire                 in_tlast,
  output logic                push,
  output adler32_pkg::item_t  push_item,
  input  wire                 q_full
);

  logic               valid_r, valid_nxt;
  adler32_pkg::item_t item_r, item_nxt;

  assign push      = valid_r && !q_full;
  assign in_tready = !valid_r || !q_full;
  assign push_item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (push) begin
      valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      valid_nxt           = 1'b1;
      item_nxt.data_byte  = in_tdata[7:0];
      item_nxt.first_byte = in_tuser;
      item_nxt.last_byte  = in_tlast;
      item_nxt.seed_a     = adler32_pkg::reduce_once({1'b0, in_tdata[23:8]});
      item_nxt.seed_b     = adler32_pkg::reduce_once({1'b0, in_tdata[39:24]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule
`default_nettype wire

// ===== src/adler32_queue.sv =====
// Short register queue between the front stage and the sum engine.
`default_nettype none
module adler32_queue #(
  parameter int DEPTH = adler32_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  adler32_pkg::item_t  push_item,
  output logic                full,
  input  wire                 pop,
  output adler32_pkg::item_t  pop_item,
  output logic                valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  adler32_pkg::item_t slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == FULL_CNT);
  assign valid    = (count_r != '0);
  assign pop_item = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== src/adler32_back.sv =====
// Sum engine: updates sums A and B per byte and holds the checksum for the receiver.
`default_nettype none
module adler32_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    q_valid,
  input  adler32_pkg::item_t     q_item,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [31:0]            out_tdata,
  output adler32_pkg::sum_stat_t stat
);

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic [15:0] sum_a_r, sum_a_nxt;
  logic [15:0] sum_b_r, sum_b_nxt;
  logic [15:0] a_src, b_src, a_new, b_new;
  logic        out_free;

  assign out_free   = !out_valid_r || out_tready;
  // A byte that closes a message waits until the output slot can take it.
  assign pop        = q_valid && (!q_item.last_byte || out_free);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign stat.sum_a = sum_a_r;
  assign stat.sum_b = sum_b_r;

  always_comb begin
    a_src = q_item.first_byte ? q_item.seed_a : sum_a_r;
    b_src = q_item.first_byte ? q_item.seed_b : sum_b_r;
    a_new = adler32_pkg::reduce_once({1'b0, a_src} + {9'd0, q_item.data_byte});
    b_new = adler32_pkg::reduce_once({1'b0, b_src} + {1'b0, a_new});

    sum_a_nxt     = sum_a_r;
    sum_b_nxt     = sum_b_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      sum_a_nxt = a_new;
      sum_b_nxt = b_new;
      if (q_item.last_byte) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {b_new, a_new};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sum_a_r     <= 16'd1;
      sum_b_r     <= 16'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ===== src/adler32_checksum_unit.sv =====
// Adler-32 checksum unit: byte stream in, one checksum per message out.
//
// Input channel in_*: one message byte per item. in_tuser marks the first byte of a
// message; on it both sums load from the seed in in_tdata (A from the low half, B from
// the high half, each reduced mod 65521) before the byte is added. in_tlast marks the
// last byte; only that item produces a result. Bytes without a first mark continue the
// running sums, also across a previous last byte.
// Output channel out_*: out_tdata = sum B in bits 31..16, sum A in bits 15..0.
// Throughput: one item per cycle while the queue is not full. A last byte passes the input
// register, a queue slot and the sum engine output register on its way to out_tvalid.
// A front register feeds a short queue (QUEUE_DEPTH items) ahead of the sum engine.
// When the receiver stalls, the held checksum stays on out_tdata; non-last bytes keep
// flowing, and the queue fills only once a second last byte waits for the output slot.
// Reset (rst_n low, synchronous) empties the pipeline and sets A = 1, B = 0.
`default_nettype none
module adler32_checksum_unit #(
  parameter int QUEUE_DEPTH = adler32_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // [7:0] data_byte, [39:8] seed
  input  wire         in_tuser,   // [0] first_byte
  input  wire         in_tlast,   // last_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata   // [31:0] checksum
);

  logic                   push, q_full, pop, q_valid;
  adler32_pkg::item_t     push_item, q_item;
  adler32_pkg::sum_stat_t stat;

  adler32_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  adler32_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (q_item),
    .valid     (q_valid)
  );

  adler32_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (stat)
  );

  a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, stat.sum_a} < adler32_pkg::ADLER_MOD) &&
    ({1'b0, stat.sum_b} < adler32_pkg::ADLER_MOD))
    else $error("running sum not below modulus");

  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[15:0]} < adler32_pkg::ADLER_MOD) &&
                   ({1'b0, out_tdata[31:16]} < adler32_pkg::ADLER_MOD))
    else $error("checksum half not below modulus");

  a_reset_sums: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (stat.sum_a == 16'd1) && (stat.sum_b == 16'd0) && !out_tvalid)
    else $error("sums not at initial values after reset");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (pop || push) |-> (!pop || q_valid) && (!push || !q_full))
    else $error("queue overrun or underrun");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the Adler-32 checksum unit: directed and random stream traffic with a running sum check.
`timescale 1ns / 100ps
module tb;

  localparam logic [16:0] MODULUS   = 17'd65521;
  localparam int          STALL_LEN = 500;
  localparam int          WATCHDOG  = 4000;
  localparam int          NUM_ITEMS = 1850;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [31:0] seed;
  } msg_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  msg_byte_t   msg_bytes[$];
  logic [31:0] checksum_q[$];
  msg_byte_t   drv_item;
  logic [15:0] acc_a = 16'd1;
  logic [15:0] acc_b = 16'd0;
  int          bytes_sent = 0;
  int          total_items = 1;
  int          errors = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          stall_armed = 1'b1;

  adler32_checksum_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] fold_mod(input logic [16:0] v);
    logic [16:0] r;
    r = v;
    if (r >= MODULUS) r = r - MODULUS;
    return r[15:0];
  endfunction

  // Running Adler-32 update; queues the checksum when the byte closes a message.
  task automatic update_sums(input logic [7:0] data, input logic first, input logic last,
                             input logic [31:0] seed);
    if (first) begin
      acc_a = fold_mod({1'b0, seed[15:0]});
      acc_b = fold_mod({1'b0, seed[31:16]});
    end
    acc_a = fold_mod({1'b0, acc_a} + {9'd0, data});
    acc_b = fold_mod({1'b0, acc_b} + {1'b0, acc_a});
    if (last) checksum_q.push_back({acc_b, acc_a});
  endtask

  function automatic msg_byte_t mk(input logic [7:0] data, input logic first,
                                   input logic last, input logic [31:0] seed);
    msg_byte_t it;
    it.data = data;
    it.first = first;
    it.last = last;
    it.seed = seed;
    return it;
  endfunction

  function automatic logic [15:0] boundary_half();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd65519;
      3: return 16'd65520;
      4: return 16'd65521;
      5: return 16'd65534;
      6: return 16'd65535;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_seed();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 32'd1;
    if (r < 70) return $urandom;
    return {boundary_half(), boundary_half()};
  endfunction

  task automatic add_random_message();
    int          kind;
    int          len;
    bit          with_first;
    bit          heavy;
    logic [31:0] seed;
    logic [7:0]  b;
    kind = $urandom_range(99);
    if (kind < 8) begin
      // noise: any combination of marks and seed
      msg_bytes.push_back(mk(8'($urandom), 1'($urandom), 1'($urandom), $urandom));
      return;
    end
    len = (kind < 88) ? $urandom_range(1, 12) : $urandom_range(13, 48);
    with_first = ($urandom_range(99) >= 8);
    heavy = ($urandom_range(99) < 20);
    seed = pick_seed();
    for (int i = 0; i < len; i++) begin
      b = (heavy && $urandom_range(3) != 0) ? 8'hff : 8'($urandom);
      msg_bytes.push_back(mk(b, with_first && i == 0, i == len - 1, seed));
    end
  endtask

  function automatic int sender_idle_pct();
    case (bytes_sent * 3 / total_items)
      0: return 21;
      1: return 55;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (bytes_sent * 3 / total_items)
      0: return 55;
      1: return 21;
      default: return 0;
    endcase
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (msg_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
        drv_item = msg_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {drv_item.seed, drv_item.data};
        in_tuser <= drv_item.first;
        in_tlast <= drv_item.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off in the no-idle phase, so the unit fills and backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (stall_armed && bytes_sent >= total_items * 3 / 4) begin
      stall_armed <= 1'b0;
      stall_left <= STALL_LEN;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (stall_left == 0) && ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // Monitor
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        update_sums(in_tdata[7:0], in_tuser, in_tlast, in_tdata[39:8]);
        bytes_sent <= bytes_sent + 1;
      end
      if (out_tvalid && out_tready) begin
        if (checksum_q.size() == 0) begin
          $display("%0t: checksum mismatch: expected none, actual %h", $time, out_tdata);
          errors++;
        end else begin
          want = checksum_q.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: checksum mismatch: expected %h, actual %h", $time, want, out_tdata);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // straight out of reset: sums start at A = 1, B = 0
    msg_bytes.push_back(mk(8'hff, 1'b0, 1'b0, 32'hffffffff));
    msg_bytes.push_back(mk(8'h00, 1'b0, 1'b1, 32'h00000000));
    // continues across the previous last byte
    msg_bytes.push_back(mk(8'h80, 1'b0, 1'b1, 32'h5a5a5a5a));
    // one-byte messages with seed halves below, at and above the modulus
    msg_bytes.push_back(mk(8'h61, 1'b1, 1'b1, 32'h00000001));
    msg_bytes.push_back(mk(8'hff, 1'b1, 1'b1, 32'hffffffff));
    msg_bytes.push_back(mk(8'h00, 1'b1, 1'b1, 32'hfff0fff0));
    msg_bytes.push_back(mk(8'h01, 1'b1, 1'b1, 32'hfff1fff1));
    msg_bytes.push_back(mk(8'hff, 1'b1, 1'b1, 32'h0000fff0));
    msg_bytes.push_back(mk(8'h00, 1'b1, 1'b1, 32'h00000000));
    msg_bytes.push_back(mk(8'h7f, 1'b1, 1'b1, 32'hfffefff2));
    // "abc" from a fresh seed
    msg_bytes.push_back(mk(8'h61, 1'b1, 1'b0, 32'h00000001));
    msg_bytes.push_back(mk(8'h62, 1'b0, 1'b0, 32'hffffffff));
    msg_bytes.push_back(mk(8'h63, 1'b0, 1'b1, 32'h00000000));
    // sums near the modulus, both wrap
    msg_bytes.push_back(mk(8'hff, 1'b1, 1'b0, 32'hfff0fff0));
    msg_bytes.push_back(mk(8'hff, 1'b0, 1'b0, 32'h00000000));
    msg_bytes.push_back(mk(8'hff, 1'b0, 1'b0, 32'h00000000));
    msg_bytes.push_back(mk(8'hff, 1'b0, 1'b1, 32'h00000000));
    // restart in mid-message
    msg_bytes.push_back(mk(8'h55, 1'b1, 1'b0, 32'h12345678));
    msg_bytes.push_back(mk(8'haa, 1'b1, 1'b0, 32'h87654321));
    msg_bytes.push_back(mk(8'h3c, 1'b0, 1'b1, 32'h00000001));
    while (msg_bytes.size() < NUM_ITEMS) add_random_message();
    total_items = msg_bytes.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (msg_bytes.size() != 0 || in_tvalid || checksum_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
